FILE: hw/rtl/ptt_pkg.sv
package ptt_pkg;

  // Fixed field widths
  localparam int unsigned FRAME_W  = 8;
  localparam int unsigned VPN_W    = 7;   // table size register width, bounds every page number
  localparam int unsigned PA_W     = 12;
  localparam int unsigned IDX_W    = 6;
  localparam int unsigned CFG_W    = 7;

  // Frames at or above this count raise a bus error
  localparam int unsigned FRAME_COUNT = 32;

  // Alignment masks and sizes that carry an alignment check
  localparam logic [31:0] WORD_ALIGN_MASK = 32'h3;
  localparam logic [31:0] HALF_ALIGN_MASK = 32'h1;
  localparam logic [2:0]  SIZE_HALF       = 3'd2;
  localparam logic [2:0]  SIZE_WORD       = 3'd4;

  typedef enum logic [1:0] {
    FUNC_XLATE = 2'd0,
    FUNC_LOAD  = 2'd1,
    FUNC_READ  = 2'd2
  } func_e;

  typedef enum logic [2:0] {
    EXC_NONE       = 3'd0,
    EXC_ADDRESS    = 3'd1,
    EXC_PAGE_FAULT = 3'd2,
    EXC_READ_ONLY  = 3'd3,
    EXC_BUS        = 3'd4
  } exc_e;

  typedef struct packed {
    logic [FRAME_W-1:0] frame;
    logic               vld;
    logic               rd_only;
    logic               used;
    logic               dirty;
  } pte_t;

  // Per-request control carried down the pipe
  typedef struct packed {
    logic [1:0] func;
    logic       writing;
    logic       misalign;
    logic       out_of_range;
    logic       idx_ok;
  } req_ctl_t;

  typedef struct packed {
    exc_e            exc;
    logic [PA_W-1:0] pa;
    pte_t            entry;
  } rsp_t;

endpackage

FILE: hw/rtl/ptt_table.sv
module ptt_table #(
  parameter int unsigned DEPTH = 64,
  parameter int unsigned AW    = 6
) (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              rd_en_i,
  input  logic [AW-1:0]     rd_addr_i,
  output ptt_pkg::pte_t     rd_entry_o,
  input  logic              wr_en_i,
  input  logic [AW-1:0]     wr_addr_i,
  input  ptt_pkg::pte_t     wr_entry_i
);

  ptt_pkg::pte_t    mem_q [DEPTH];
  logic [DEPTH-1:0] filled_q;
  ptt_pkg::pte_t    rd_data_q;
  logic             rd_filled_q;
  logic             bypass;

  // A write on the same edge as a read of the same entry wins
  assign bypass = wr_en_i && (wr_addr_i == rd_addr_i);

  always_ff @(posedge clk_i) begin
    if (wr_en_i) begin
      mem_q[wr_addr_i] <= wr_entry_i;
    end
    if (rd_en_i) begin
      rd_data_q <= bypass ? wr_entry_i : mem_q[rd_addr_i];
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      filled_q    <= '0;
      rd_filled_q <= 1'b0;
    end else begin
      if (wr_en_i) begin
        filled_q[wr_addr_i] <= 1'b1;
      end
      if (rd_en_i) begin
        rd_filled_q <= bypass || filled_q[rd_addr_i];
      end
    end
  end

  // Entries never written read as zero
  assign rd_entry_o = rd_filled_q ? rd_data_q : '0;

endmodule

FILE: hw/rtl/ptt_check.sv
module ptt_check #(
  parameter int unsigned PAGE_BYTES = 128
) (
  input  ptt_pkg::req_ctl_t               ctl_i,
  input  ptt_pkg::pte_t                   entry_i,
  input  logic [$clog2(PAGE_BYTES)-1:0]   off_i,
  input  ptt_pkg::pte_t                   load_i,
  output ptt_pkg::rsp_t                   rsp_o,
  output logic                            wb_en_o,
  output ptt_pkg::pte_t                   wb_entry_o
);

  localparam int unsigned PA_W = ptt_pkg::PA_W;

  logic frame_bad;

  assign frame_bad = {1'b0, entry_i.frame} >= 9'(ptt_pkg::FRAME_COUNT);

  always_comb begin
    rsp_o      = '0;
    wb_en_o    = 1'b0;
    wb_entry_o = entry_i;
    unique case (ctl_i.func)
      ptt_pkg::FUNC_XLATE: begin
        priority if (ctl_i.misalign || ctl_i.out_of_range) begin
          rsp_o.exc = ptt_pkg::EXC_ADDRESS;
        end else if (!entry_i.vld) begin
          rsp_o.exc = ptt_pkg::EXC_PAGE_FAULT;
        end else if (entry_i.rd_only && ctl_i.writing) begin
          rsp_o.exc = ptt_pkg::EXC_READ_ONLY;
        end else if (frame_bad) begin
          rsp_o.exc = ptt_pkg::EXC_BUS;
        end else begin
          rsp_o.pa = PA_W'(PA_W'(entry_i.frame) * PA_W'(PAGE_BYTES) + PA_W'(off_i));
          wb_en_o          = 1'b1;
          wb_entry_o.used  = 1'b1;
          wb_entry_o.dirty = entry_i.dirty | ctl_i.writing;
        end
      end
      ptt_pkg::FUNC_LOAD: begin
        wb_en_o    = ctl_i.idx_ok;
        wb_entry_o = load_i;
      end
      ptt_pkg::FUNC_READ: begin
        if (ctl_i.idx_ok) begin
          rsp_o.entry = entry_i;
        end
      end
      default: begin
      end
    endcase
  end

endmodule

FILE: hw/rtl/page_table_translation_unit.sv
// Throughput: one request per cycle; four pipeline registers (input, page split,
// table read, result) each stall only when the stage after them is full.
// Reset: all stage valids drop, the table reads as all-zero entries and the
// table size in use is 0; the entry store itself is not swept.
module page_table_translation_unit #(
  parameter int unsigned PAGE_BYTES  = 128,
  parameter int unsigned TABLE_DEPTH = 64
) (
  input  logic                            clk_i,
  input  logic                            rst_ni,
  // table size register
  input  logic                            cfg_we_i,
  input  logic [ptt_pkg::CFG_W-1:0]       cfg_wdata_i,
  // request channel
  input  logic                            req_valid_i,
  output logic                            req_ready_o,
  input  logic [1:0]                      func_i,
  input  logic [31:0]                     virt_addr_i,
  input  logic [2:0]                      access_size_i,
  input  logic                            writing_i,
  input  logic [ptt_pkg::IDX_W-1:0]       entry_index_i,
  input  logic [ptt_pkg::FRAME_W-1:0]     entry_frame_i,
  input  logic                            entry_valid_i,
  input  logic                            entry_read_only_i,
  input  logic                            entry_use_i,
  input  logic                            entry_dirty_i,
  // response channel
  output logic                            rsp_valid_o,
  input  logic                            rsp_ready_i,
  output logic [2:0]                      exception_code_o,
  output logic [ptt_pkg::PA_W-1:0]        phys_addr_o,
  output logic [ptt_pkg::FRAME_W-1:0]     out_frame_o,
  output logic                            out_valid_o,
  output logic                            out_read_only_o,
  output logic                            out_use_o,
  output logic                            out_dirty_o
);

  localparam int unsigned VPN_W = ptt_pkg::VPN_W;
  // Only the first 127 entries can ever be reached: page numbers stay below
  // the 7-bit table size and load indexes below 64.
  localparam int unsigned MEM_DEPTH = (TABLE_DEPTH < 127) ? TABLE_DEPTH : 127;
  localparam int unsigned MEM_AW    = (MEM_DEPTH > 1) ? $clog2(MEM_DEPTH) : 1;
  localparam int unsigned OFF_W     = $clog2(PAGE_BYTES);
  // Addresses below the table limit fit in VA_W bits
  localparam int unsigned VA_W      = $clog2(MEM_DEPTH * PAGE_BYTES);
  // Page number by reciprocal multiply, exact for any VA_W-bit address
  localparam int unsigned SHIFT     = VA_W + OFF_W;
  localparam logic [63:0] RECIP     = ((64'd1 << SHIFT) + 64'(PAGE_BYTES) - 64'd1)
                                      / 64'(PAGE_BYTES);
  localparam int unsigned PROD_W    = SHIFT + VPN_W;
  localparam int unsigned LB_W      = VPN_W + OFF_W;
  localparam int unsigned DEPTH_CW  = 13;

  // --------------------------------------------------------------------------
  // Table size register, held as a byte limit so the range check is a compare
  // --------------------------------------------------------------------------
  logic [LB_W-1:0]  lim_bytes_q, lim_bytes_d;
  logic [VPN_W-1:0] lim_entries;

  always_comb begin
    lim_entries = (DEPTH_CW'(cfg_wdata_i) > DEPTH_CW'(TABLE_DEPTH)) ?
                  VPN_W'(TABLE_DEPTH) : cfg_wdata_i;
    lim_bytes_d = LB_W'(LB_W'(lim_entries) * LB_W'(PAGE_BYTES));
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      lim_bytes_q <= '0;
    end else if (cfg_we_i) begin
      lim_bytes_q <= lim_bytes_d;
    end
  end

  // --------------------------------------------------------------------------
  // Pipeline flow: each stage advances when the next one is empty or moving
  // --------------------------------------------------------------------------
  logic s0_vld_q, s1_vld_q, s2_vld_q, rsp_vld_q;
  logic rdy0, rdy1, rdy2, rdy_rsp;
  logic acc, mv0, mv1, mv2;

  assign rdy_rsp     = !rsp_vld_q || rsp_ready_i;
  assign rdy2        = !s2_vld_q || rdy_rsp;
  assign rdy1        = !s1_vld_q || rdy2;
  assign rdy0        = !s0_vld_q || rdy1;
  assign req_ready_o = rdy0;

  assign acc = req_valid_i && rdy0;
  assign mv0 = s0_vld_q && rdy1;
  assign mv1 = s1_vld_q && rdy2;
  assign mv2 = s2_vld_q && rdy_rsp;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s0_vld_q  <= 1'b0;
      s1_vld_q  <= 1'b0;
      s2_vld_q  <= 1'b0;
      rsp_vld_q <= 1'b0;
    end else begin
      s0_vld_q  <= acc || (s0_vld_q && !mv0);
      s1_vld_q  <= mv0 || (s1_vld_q && !mv1);
      s2_vld_q  <= mv1 || (s2_vld_q && !mv2);
      rsp_vld_q <= mv2 || (rsp_vld_q && !rsp_ready_i);
    end
  end

  // --------------------------------------------------------------------------
  // Stage 0: input register; alignment, range check and page number product
  // --------------------------------------------------------------------------
  logic [1:0]                  s0_func_q;
  logic [31:0]                 s0_va_q;
  logic [2:0]                  s0_size_q;
  logic                        s0_wr_q;
  logic [ptt_pkg::IDX_W-1:0]   s0_idx_q;
  ptt_pkg::pte_t               s0_load_q;

  always_ff @(posedge clk_i) begin
    if (acc) begin
      s0_func_q         <= func_i;
      s0_va_q           <= virt_addr_i;
      s0_size_q         <= access_size_i;
      s0_wr_q           <= writing_i;
      s0_idx_q          <= entry_index_i;
      s0_load_q.frame   <= entry_frame_i;
      s0_load_q.vld     <= entry_valid_i;
      s0_load_q.rd_only <= entry_read_only_i;
      s0_load_q.used    <= entry_use_i;
      s0_load_q.dirty   <= entry_dirty_i;
    end
  end

  ptt_pkg::req_ctl_t s0_ctl;
  logic [PROD_W-1:0] s0_prod;
  logic [VPN_W-1:0]  s0_vpn;

  always_comb begin
    s0_ctl.func     = s0_func_q;
    s0_ctl.writing  = s0_wr_q;
    s0_ctl.misalign =
        ((s0_size_q == ptt_pkg::SIZE_WORD) && ((s0_va_q & ptt_pkg::WORD_ALIGN_MASK) != '0)) ||
        ((s0_size_q == ptt_pkg::SIZE_HALF) && ((s0_va_q & ptt_pkg::HALF_ALIGN_MASK) != '0));
    // page number >= limit exactly when address >= limit * page size
    s0_ctl.out_of_range = s0_va_q >= 32'(lim_bytes_q);
    s0_ctl.idx_ok       = DEPTH_CW'(s0_idx_q) < DEPTH_CW'(TABLE_DEPTH);
    // only meaningful while the address is in range, hence below 2**VA_W
    s0_prod = PROD_W'(PROD_W'(s0_va_q[VA_W-1:0]) * PROD_W'(RECIP));
    s0_vpn  = s0_prod[SHIFT +: VPN_W];
  end

  // --------------------------------------------------------------------------
  // Stage 1: page offset, table read address
  // --------------------------------------------------------------------------
  ptt_pkg::req_ctl_t  s1_ctl_q;
  logic [VPN_W-1:0]   s1_vpn_q;
  logic [OFF_W-1:0]   s1_va_lo_q;
  logic [ptt_pkg::IDX_W-1:0] s1_idx_q;
  ptt_pkg::pte_t      s1_load_q;

  always_ff @(posedge clk_i) begin
    if (mv0) begin
      s1_ctl_q   <= s0_ctl;
      s1_vpn_q   <= s0_vpn;
      s1_va_lo_q <= s0_va_q[OFF_W-1:0];
      s1_idx_q   <= s0_idx_q;
      s1_load_q  <= s0_load_q;
    end
  end

  logic [OFF_W-1:0]  s1_off;
  logic [VPN_W-1:0]  s1_sel;
  logic [MEM_AW-1:0] tbl_rd_addr;
  logic              s1_xlate_ok;
  logic              s1_rd_need;
  logic              tbl_rd_en;

  always_comb begin
    // offset modulo 2**OFF_W is exact since it stays below the page size
    s1_off      = s1_va_lo_q - OFF_W'(OFF_W'(s1_vpn_q) * OFF_W'(PAGE_BYTES));
    s1_xlate_ok = (s1_ctl_q.func == ptt_pkg::FUNC_XLATE) &&
                  !s1_ctl_q.misalign && !s1_ctl_q.out_of_range;
    s1_rd_need  = s1_xlate_ok ||
                  ((s1_ctl_q.func == ptt_pkg::FUNC_READ) && s1_ctl_q.idx_ok);
    s1_sel      = (s1_ctl_q.func == ptt_pkg::FUNC_XLATE) ? s1_vpn_q : VPN_W'(s1_idx_q);
    tbl_rd_addr = s1_sel[MEM_AW-1:0];
    tbl_rd_en   = mv1 && s1_rd_need;
  end

  // --------------------------------------------------------------------------
  // Stage 2: entry from the table, checks and write-back
  // --------------------------------------------------------------------------
  ptt_pkg::req_ctl_t  s2_ctl_q;
  logic [OFF_W-1:0]   s2_off_q;
  logic [MEM_AW-1:0]  s2_addr_q;
  ptt_pkg::pte_t      s2_load_q;

  always_ff @(posedge clk_i) begin
    if (mv1) begin
      s2_ctl_q  <= s1_ctl_q;
      s2_off_q  <= s1_off;
      s2_addr_q <= tbl_rd_addr;
      s2_load_q <= s1_load_q;
    end
  end

  ptt_pkg::pte_t tbl_entry;
  ptt_pkg::rsp_t s2_rsp;
  logic          wb_en;
  ptt_pkg::pte_t wb_entry;
  logic          tbl_wr_en;

  // write back only as the request leaves, so a stalled request writes once
  assign tbl_wr_en = mv2 && wb_en;

  ptt_table #(
    .DEPTH (MEM_DEPTH),
    .AW    (MEM_AW)
  ) u_table (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .rd_en_i    (tbl_rd_en),
    .rd_addr_i  (tbl_rd_addr),
    .rd_entry_o (tbl_entry),
    .wr_en_i    (tbl_wr_en),
    .wr_addr_i  (s2_addr_q),
    .wr_entry_i (wb_entry)
  );

  ptt_check #(
    .PAGE_BYTES (PAGE_BYTES)
  ) u_check (
    .ctl_i      (s2_ctl_q),
    .entry_i    (tbl_entry),
    .off_i      (s2_off_q),
    .load_i     (s2_load_q),
    .rsp_o      (s2_rsp),
    .wb_en_o    (wb_en),
    .wb_entry_o (wb_entry)
  );

  // --------------------------------------------------------------------------
  // Result register: hold the beat until it is taken
  // --------------------------------------------------------------------------
  ptt_pkg::rsp_t rsp_q;

  always_ff @(posedge clk_i) begin
    if (mv2) begin
      rsp_q <= s2_rsp;
    end
  end

  assign rsp_valid_o      = rsp_vld_q;
  assign exception_code_o = rsp_q.exc;
  assign phys_addr_o      = rsp_q.pa;
  assign out_frame_o      = rsp_q.entry.frame;
  assign out_valid_o      = rsp_q.entry.vld;
  assign out_read_only_o  = rsp_q.entry.rd_only;
  assign out_use_o        = rsp_q.entry.used;
  assign out_dirty_o      = rsp_q.entry.dirty;

  // --------------------------------------------------------------------------
  // Assertions
  // --------------------------------------------------------------------------
  // table accesses stay inside the reachable entries
  a_rd_in_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    tbl_rd_en |-> (32'(tbl_rd_addr) < MEM_DEPTH))
    else $error("table read beyond depth");

  a_wr_in_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    tbl_wr_en |-> (32'(s2_addr_q) < MEM_DEPTH))
    else $error("table write beyond depth");

  // a clean translation leaves the entry marked as used
  a_use_set: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (mv2 && (s2_ctl_q.func == ptt_pkg::FUNC_XLATE) && (s2_rsp.exc == ptt_pkg::EXC_NONE))
    |-> (tbl_wr_en && wb_entry.used))
    else $error("translation without use mark update");

  // a faulting beat never carries an address
  a_fault_no_pa: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (rsp_valid_o && (exception_code_o != ptt_pkg::EXC_NONE)) |-> (phys_addr_o == '0))
    else $error("address on a faulting result");

endmodule
